@@ hdl/tswo_pkg.sv @@
// Shared constants and helper functions for the torus surface wrap pipeline.
package tswo_pkg;

  localparam int GUARD_BITS = 8;
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJOR_RADIUS = 1'b0,
    CFG_MINOR_RADIUS = 1'b1
  } cfg_idx_e;

  // arctangent of 2^-i in turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // round half up a 2^32 turn angle to 2^16 per turn
  function automatic logic [15:0] round_turn16(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h00008000;
    return s[31:16];
  endfunction

  // product in Q30 -> round half up, saturate to signed 32 bits
  function automatic logic [31:0] sat_round30(input logic signed [71:0] p);
    logic signed [71:0] t;
    t = (p + 72'sh20000000) >>> 30;
    if (t > 72'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (t < 72'shFF_FFFF_FFFF_8000_0000) return 32'h80000000;
    return t[31:0];
  endfunction

endpackage

@@ hdl/torus_surface_wrap_with_offset_top.sv @@
// Top level: fully pipelined torus coordinate wrap built from CORDIC cell rows.
//
// Usage:
//  - Request channel: drive pos_x_i/pos_y_i/pos_z_i (signed Q16.16) and the
//    two 16-bit turn offsets with start high. A request is taken at every
//    rising edge where start is high and busy is low; busy never rises, so
//    one request may enter every cycle.
//  - Result channel: out_valid_o pulses for exactly one cycle with
//    out_x_o/out_y_o/out_z_o. There is no back-pressure; results are in
//    request order.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (0 = major radius, 1 = minor radius) at once. Write only when no
//    request is in flight.
//  - Pipeline: three rows of CORDIC cells (theta vectoring, phi vectoring,
//    dual-lane rotation) plus the magnitude scaling and output multiplier
//    stages. Throughput: 1/cycle.
//  - Reset (rst_ni low, async) clears the pipeline valid bits and loads
//    the default radii; requests in flight are dropped.
module torus_surface_wrap_with_offset_top import tswo_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic [15:0]          theta_offset_i,
  input  logic [15:0]          phi_offset_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [30:0]          cfg_data_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   out_x_o,
  output logic signed [31:0]   out_y_o,
  output logic signed [31:0]   out_z_o
);

  localparam int N   = CORDIC_STAGES;
  localparam int W1  = 44;
  localparam int W2  = 46;
  localparam int WR  = 34;
  localparam int PW  = 32 + GUARD_BITS;
  localparam int SW1 = 1 + PW + 32;
  localparam int SW2 = 33;
  localparam int LAT = 3 * N + 10;

  assign busy = 1'b0;

  // configuration
  logic [30:0] major_q, minor_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= 31'd655360;
      minor_q <= 31'd196608;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAJOR_RADIUS: major_q <= cfg_data_i;
        CFG_MINOR_RADIUS: minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: scale, half-turn pre-rotation for theta
  logic signed [W1-1:0] px_s, pz_s;
  logic                 zero1;
  assign px_s  = W1'(pos_x_i) <<< GUARD_BITS;
  assign pz_s  = W1'(pos_z_i) <<< GUARD_BITS;
  assign zero1 = (pos_x_i == 32'sd0) && (pos_z_i == 32'sd0);

  logic                 v1 [N+1];
  logic signed [W1-1:0] x1 [N+1];
  logic signed [W1-1:0] y1 [N+1];
  logic [31:0]          a1 [N+1];
  logic [SW1-1:0]       s1 [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1[0] <= 1'b0;
    else v1[0] <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    if (pos_x_i[31]) begin
      x1[0] <= -px_s;
      y1[0] <= -pz_s;
      a1[0] <= 32'h80000000;
    end else begin
      x1[0] <= px_s;
      y1[0] <= pz_s;
      a1[0] <= 32'h0;
    end
    s1[0] <= {zero1, PW'(pos_y_i) <<< GUARD_BITS, theta_offset_i, phi_offset_i};
  end

  for (genvar i = 0; i < N; i++) begin : g_vec1
    tswo_vec_cell #(.W(W1), .IDX(i), .SW(SW1)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(v1[i]), .x_i(x1[i]), .y_i(y1[i]), .a_i(a1[i]), .side_i(s1[i]),
      .valid_o(v1[i+1]), .x_o(x1[i+1]), .y_o(y1[i+1]), .a_o(a1[i+1]),
      .side_o(s1[i+1])
    );
  end

  // ---------------- M1: gain-correct magnitude (split 44x32 product)
  logic            e_zero1;
  logic [PW-1:0]   e_py;
  logic [15:0]     e_toff, e_poff;
  logic [31:0]     th_a;
  assign {e_zero1, e_py, e_toff, e_poff} = s1[N];
  assign th_a = e_zero1 ? 32'h0 : a1[N];

  logic            m1_v_q;
  logic [43:0]     prod_hi_q;
  logic [63:0]     prod_lo_q;
  logic [15:0]     m1_th_q, m1_poff_q;
  logic [PW-1:0]   m1_py_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_v_q <= 1'b0;
    else m1_v_q <= v1[N];
  end
  always_ff @(posedge clk_i) begin
    prod_hi_q <= 44'(x1[N][43:32]) * 44'(INV_GAIN);
    prod_lo_q <= 64'(x1[N][31:0]) * 64'(INV_GAIN);
    m1_th_q   <= round_turn16(th_a) + e_toff;
    m1_poff_q <= e_poff;
    m1_py_q   <= e_py;
  end

  // ---------------- M2: signed radial distance d = rho - R
  logic                 m2_v_q;
  logic signed [W2-1:0] d_q;
  logic [15:0]          m2_th_q, m2_poff_q;
  logic [PW-1:0]        m2_py_q;
  logic [44:0]          rho;
  assign rho = {1'b0, prod_hi_q} + 45'(prod_lo_q[63:32]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_v_q <= 1'b0;
    else m2_v_q <= m1_v_q;
  end
  always_ff @(posedge clk_i) begin
    d_q       <= $signed(W2'(rho)) - $signed(W2'(major_q) <<< GUARD_BITS);
    m2_th_q   <= m1_th_q;
    m2_poff_q <= m1_poff_q;
    m2_py_q   <= m1_py_q;
  end

  // ---------------- M3: half-turn pre-rotation for phi
  logic                 v2 [N+1];
  logic signed [W2-1:0] x2 [N+1];
  logic signed [W2-1:0] y2 [N+1];
  logic [31:0]          a2 [N+1];
  logic [SW2-1:0]       s2 [N+1];
  logic signed [W2-1:0] py_w;
  assign py_w = W2'($signed(m2_py_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2[0] <= 1'b0;
    else v2[0] <= m2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (d_q[W2-1]) begin
      x2[0] <= -d_q;
      y2[0] <= -py_w;
      a2[0] <= 32'h80000000;
    end else begin
      x2[0] <= d_q;
      y2[0] <= py_w;
      a2[0] <= 32'h0;
    end
    s2[0] <= {(d_q == '0) && (py_w == '0), m2_th_q, m2_poff_q};
  end

  for (genvar i = 0; i < N; i++) begin : g_vec2
    tswo_vec_cell #(.W(W2), .IDX(i), .SW(SW2)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(v2[i]), .x_i(x2[i]), .y_i(y2[i]), .a_i(a2[i]), .side_i(s2[i]),
      .valid_o(v2[i+1]), .x_o(x2[i+1]), .y_o(y2[i+1]), .a_o(a2[i+1]),
      .side_o(s2[i+1])
    );
  end

  // ---------------- R0: wrap phi, set up both rotations
  logic        f_zero2;
  logic [15:0] f_th, f_poff, ph16;
  logic [31:0] ang [2];
  assign {f_zero2, f_th, f_poff} = s2[N];
  assign ph16   = round_turn16(f_zero2 ? 32'h0 : a2[N]) + f_poff;
  assign ang[0] = {f_th, 16'h0};
  assign ang[1] = {ph16, 16'h0};

  logic                 v3 [N+1];
  logic signed [WR-1:0] x3 [N+1][2];
  logic signed [WR-1:0] y3 [N+1][2];
  logic [31:0]          z3 [N+1][2];
  logic [1:0]           s3 [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3[0] <= 1'b0;
    else v3[0] <= v2[N];
  end
  for (genvar l = 0; l < 2; l++) begin : g_rprep
    logic flip;
    assign flip = ang[l][31] ^ ang[l][30];
    always_ff @(posedge clk_i) begin
      x3[0][l] <= WR'(INV_GAIN >> 2);
      y3[0][l] <= '0;
      z3[0][l] <= flip ? (ang[l] ^ 32'h80000000) : ang[l];
      s3[0][l] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    tswo_rot_cell #(.W(WR), .IDX(i), .SW(2)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(v3[i]), .x_i(x3[i]), .y_i(y3[i]), .z_i(z3[i]), .side_i(s3[i]),
      .valid_o(v3[i+1]), .x_o(x3[i+1]), .y_o(y3[i+1]), .z_o(z3[i+1]),
      .side_o(s3[i+1])
    );
  end

  // ---------------- C: undo half-turn, cos/sin in Q30
  logic                 c_v_q;
  logic signed [WR-1:0] ct_q, st_q, cp_q, sp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else c_v_q <= v3[N];
  end
  always_ff @(posedge clk_i) begin
    ct_q <= s3[N][0] ? -x3[N][0] : x3[N][0];
    st_q <= s3[N][0] ? -y3[N][0] : y3[N][0];
    cp_q <= s3[N][1] ? -x3[N][1] : x3[N][1];
    sp_q <= s3[N][1] ? -y3[N][1] : y3[N][1];
  end

  // ---------------- P1: r*cos(phi), r*sin(phi)
  logic                 p1_v_q;
  logic signed [65:0]   rcp_q, rsp_q;
  logic signed [WR-1:0] p1_ct_q, p1_st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else p1_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) begin
    rcp_q   <= 66'($signed({1'b0, minor_q})) * 66'(cp_q);
    rsp_q   <= 66'($signed({1'b0, minor_q})) * 66'(sp_q);
    p1_ct_q <= ct_q;
    p1_st_q <= st_q;
  end

  // ---------------- P2: w = R + round(r*cos(phi)), y result
  logic                 p2_v_q;
  logic signed [35:0]   w_q;
  logic [31:0]          p2_y_q;
  logic signed [WR-1:0] p2_ct_q, p2_st_q;
  logic signed [65:0]   rc_full;
  assign rc_full = (rcp_q + 66'sh20000000) >>> 30;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else p2_v_q <= p1_v_q;
  end
  always_ff @(posedge clk_i) begin
    w_q     <= $signed(36'(major_q)) + rc_full[35:0];
    p2_y_q  <= sat_round30(72'(rsp_q));
    p2_ct_q <= p1_ct_q;
    p2_st_q <= p1_st_q;
  end

  // ---------------- P3: w*cos(theta), w*sin(theta)
  logic               p3_v_q;
  logic signed [71:0] wx_q, wz_q;
  logic [31:0]        p3_y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else p3_v_q <= p2_v_q;
  end
  always_ff @(posedge clk_i) begin
    wx_q   <= 72'(w_q) * 72'(p2_ct_q);
    wz_q   <= 72'(w_q) * 72'(p2_st_q);
    p3_y_q <= p2_y_q;
  end

  // ---------------- P4: round, saturate, present result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else out_valid_o <= p3_v_q;
  end
  always_ff @(posedge clk_i) begin
    out_x_o <= sat_round30(wx_q);
    out_y_o <= p3_y_q;
    out_z_o <= sat_round30(wz_q);
  end

`ifndef SYNTHESIS
  // every result traces back to an earlier accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // a point on the y axis gives theta equal to the offset alone
  a_axis_theta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1[N] && e_zero1) |=> (m1_th_q == $past(e_toff)))
    else $error("theta not forced to offset on the y axis");

  // the pipeline never holds requests off
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
`endif

endmodule

@@ hdl/tswo_vec_cell.sv @@
// One vectoring CORDIC step: rotates (x, y) toward y = 0, accumulates the angle.
module tswo_vec_cell import tswo_pkg::*; #(
  parameter int W   = 44,
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [31:0]         a_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic [31:0]         a_o,
  output logic [SW-1:0]       side_o
);

  logic signed [W-1:0] dx, dy;
  assign dx = x_i >>> IDX;
  assign dy = y_i >>> IDX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    if (!y_i[W-1]) begin
      x_o <= x_i + dy;
      y_o <= y_i - dx;
      a_o <= a_i + atan_turn(IDX);
    end else begin
      x_o <= x_i - dy;
      y_o <= y_i + dx;
      a_o <= a_i - atan_turn(IDX);
    end
  end

endmodule

@@ hdl/tswo_rot_cell.sv @@
// One rotation CORDIC step, two lanes (theta and phi) side by side.
module tswo_rot_cell import tswo_pkg::*; #(
  parameter int W   = 34,
  parameter int IDX = 0,
  parameter int SW  = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] x_i [2],
  input  logic signed [W-1:0] y_i [2],
  input  logic [31:0]         z_i [2],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic signed [W-1:0] x_o [2],
  output logic signed [W-1:0] y_o [2],
  output logic [31:0]         z_o [2],
  output logic [SW-1:0]       side_o
);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= valid_i;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [W-1:0] dx, dy;
    assign dx = x_i[l] >>> IDX;
    assign dy = y_i[l] >>> IDX;
    always_ff @(posedge clk_i) begin
      if (z_i[l][31]) begin
        x_o[l] <= x_i[l] + dy;
        y_o[l] <= y_i[l] - dx;
        z_o[l] <= z_i[l] + atan_turn(IDX);
      end else begin
        x_o[l] <= x_i[l] - dy;
        y_o[l] <= y_i[l] + dx;
        z_o[l] <= z_i[l] - atan_turn(IDX);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
  end

endmodule
